@@ rtl/core/tbc_pkg.sv @@
// shared constants and types for the triangle barycentric weight pipeline
`timescale 1ns / 1ps
package tbc_pkg;

   localparam int COORD_WIDTH_DEF      = 16;
   localparam int WEIGHT_FRAC_BITS_DEF = 16;
   localparam int WEIGHT_WIDTH         = 32;
   localparam int QUOT_BITS            = 32;
   localparam int THRESH_WIDTH         = 32;
   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 32'd4295;

   typedef enum logic [1:0] {
      LANE_DIV,
      LANE_ZERO,
      LANE_HALF
   } lane_mode_type;

endpackage

@@ rtl/core/triangle_barycentric_coords.sv @@
// Barycentric weights of a point against a 3D triangle, fully pipelined. One transaction
// is taken every cycle while the result side takes results; each request passes the edge
// dot products, Gram determinant and numerator multiplies, then the 32 one-bit stages of
// the two quotient units. The whole pipeline holds when a finished result is not taken.
// Degenerate triangles (|det| at or below the threshold) fall back to projection onto the
// longer of edges ab and ac.
`timescale 1ns / 1ps
module triangle_barycentric_coords #(
   parameter int COORD_WIDTH      = tbc_pkg::COORD_WIDTH_DEF,
   parameter int WEIGHT_FRAC_BITS = tbc_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [COORD_WIDTH-1:0]         req_a_x,
   input  logic signed [COORD_WIDTH-1:0]         req_a_y,
   input  logic signed [COORD_WIDTH-1:0]         req_a_z,
   input  logic signed [COORD_WIDTH-1:0]         req_b_x,
   input  logic signed [COORD_WIDTH-1:0]         req_b_y,
   input  logic signed [COORD_WIDTH-1:0]         req_b_z,
   input  logic signed [COORD_WIDTH-1:0]         req_c_x,
   input  logic signed [COORD_WIDTH-1:0]         req_c_y,
   input  logic signed [COORD_WIDTH-1:0]         req_c_z,
   input  logic signed [COORD_WIDTH-1:0]         req_p_x,
   input  logic signed [COORD_WIDTH-1:0]         req_p_y,
   input  logic signed [COORD_WIDTH-1:0]         req_p_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [tbc_pkg::WEIGHT_WIDTH-1:0] rsp_weight_a,
   output logic signed [tbc_pkg::WEIGHT_WIDTH-1:0] rsp_weight_b,
   output logic signed [tbc_pkg::WEIGHT_WIDTH-1:0] rsp_weight_c,
   output logic                                  rsp_degenerate,
   input  logic                                  csr_write_enable,
   input  logic [tbc_pkg::THRESH_WIDTH-1:0]      csr_write_data
);
   import tbc_pkg::*;

   localparam int DFW = COORD_WIDTH + 1;
   localparam int PW  = 2 * DFW;
   localparam int DW  = PW + 2;
   localparam int H   = DW / 2;
   localparam int HW  = DW - H;
   localparam int LPW = DW + H + 1;
   localparam int HPW = DW + HW;
   localparam int BPW = 2 * DW;
   localparam int NW  = BPW + 1;
   localparam int RW  = NW + QUOT_BITS;
   localparam int WW  = WEIGHT_WIDTH;
   localparam int SW  = WW + 2;

   logic adv;
   logic [THRESH_WIDTH-1:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_write_enable) begin
         thresh_ff <= csr_write_data;
      end
   end

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // stage 1: edge and offset vectors
   logic signed [COORD_WIDTH-1:0] va [3], vb [3], vc [3], vp [3];
   logic signed [DFW-1:0] e0_ff [3], e1_ff [3], ev_ff [3];
   logic v1_ff;

   assign va = '{req_a_x, req_a_y, req_a_z};
   assign vb = '{req_b_x, req_b_y, req_b_z};
   assign vc = '{req_c_x, req_c_y, req_c_z};
   assign vp = '{req_p_x, req_p_y, req_p_z};

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            e0_ff[i] <= DFW'(vb[i]) - DFW'(va[i]);
            e1_ff[i] <= DFW'(vc[i]) - DFW'(va[i]);
            ev_ff[i] <= DFW'(vp[i]) - DFW'(va[i]);
         end
      end
   end

   // stage 2: component products
   logic signed [PW-1:0] p00_ff [3], p01_ff [3], p11_ff [3], p20_ff [3], p21_ff [3];
   logic v2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            p00_ff[i] <= e0_ff[i] * e0_ff[i];
            p01_ff[i] <= e0_ff[i] * e1_ff[i];
            p11_ff[i] <= e1_ff[i] * e1_ff[i];
            p20_ff[i] <= ev_ff[i] * e0_ff[i];
            p21_ff[i] <= ev_ff[i] * e1_ff[i];
         end
      end
   end

   // stage 3: dot products
   logic signed [DW-1:0] d00_ff, d01_ff, d11_ff, d20_ff, d21_ff;
   logic v3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         d00_ff <= DW'(p00_ff[0]) + DW'(p00_ff[1]) + DW'(p00_ff[2]);
         d01_ff <= DW'(p01_ff[0]) + DW'(p01_ff[1]) + DW'(p01_ff[2]);
         d11_ff <= DW'(p11_ff[0]) + DW'(p11_ff[1]) + DW'(p11_ff[2]);
         d20_ff <= DW'(p20_ff[0]) + DW'(p20_ff[1]) + DW'(p20_ff[2]);
         d21_ff <= DW'(p21_ff[0]) + DW'(p21_ff[1]) + DW'(p21_ff[2]);
      end
   end

   // stage 4: split partial products of the determinant and numerator terms
   logic signed [DW-1:0] mul_a [6], mul_b [6];
   logic signed [LPW-1:0] pl_ff [6];
   logic signed [HPW-1:0] ph_ff [6];
   logic signed [DW-1:0] d00_s4_ff, d11_s4_ff, d20_s4_ff, d21_s4_ff;
   logic v4_ff;

   assign mul_a = '{d00_ff, d01_ff, d11_ff, d01_ff, d00_ff, d01_ff};
   assign mul_b = '{d11_ff, d01_ff, d20_ff, d21_ff, d21_ff, d20_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 6; k++) begin
            pl_ff[k] <= mul_a[k] * $signed({1'b0, mul_b[k][H-1:0]});
            ph_ff[k] <= mul_a[k] * $signed(mul_b[k][DW-1:H]);
         end
         d00_s4_ff <= d00_ff;
         d11_s4_ff <= d11_ff;
         d20_s4_ff <= d20_ff;
         d21_s4_ff <= d21_ff;
      end
   end

   // stage 5: determinant and numerators
   logic signed [BPW-1:0] full [6];
   logic signed [NW-1:0] det_ff, numb_ff, numc_ff;
   logic signed [DW-1:0] d00_s5_ff, d11_s5_ff, d20_s5_ff, d21_s5_ff;
   logic v5_ff;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         full[k] = (BPW'(ph_ff[k]) <<< H) + BPW'(pl_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff    <= NW'(full[0]) - NW'(full[1]);
         numb_ff   <= NW'(full[2]) - NW'(full[3]);
         numc_ff   <= NW'(full[4]) - NW'(full[5]);
         d00_s5_ff <= d00_s4_ff;
         d11_s5_ff <= d11_s4_ff;
         d20_s5_ff <= d20_s4_ff;
         d21_s5_ff <= d21_s4_ff;
      end
   end

   // stage 6: degenerate test and quotient operand selection
   logic [NW-1:0] det_mag;
   logic is_deg, b_longer;
   logic signed [NW-1:0] sel_num [2], sel_den [2];
   lane_mode_type sel_mode [2];
   logic [NW-1:0] num_mag [2], den_mag [2];
   logic [RW-1:0] n6_ff [2];
   logic [NW-1:0] dn6_ff [2];
   logic neg6_ff [2];
   lane_mode_type mode6_ff [2];
   logic deg6_ff;
   logic v6_ff;

   always_comb begin
      det_mag  = det_ff[NW-1] ? NW'(-det_ff) : NW'(det_ff);
      is_deg   = det_mag <= NW'(thresh_ff);
      b_longer = d00_s5_ff > d11_s5_ff;
      if (is_deg) begin
         sel_num[0] = NW'(d20_s5_ff);
         sel_den[0] = NW'(d00_s5_ff);
         sel_num[1] = NW'(d21_s5_ff);
         sel_den[1] = NW'(d11_s5_ff);
         if (b_longer) begin
            sel_mode[0] = (d00_s5_ff == '0) ? LANE_HALF : LANE_DIV;
            sel_mode[1] = LANE_ZERO;
         end else begin
            sel_mode[0] = LANE_ZERO;
            sel_mode[1] = (d11_s5_ff == '0) ? LANE_HALF : LANE_DIV;
         end
      end else begin
         sel_num[0]  = numb_ff;
         sel_den[0]  = det_ff;
         sel_num[1]  = numc_ff;
         sel_den[1]  = det_ff;
         sel_mode[0] = LANE_DIV;
         sel_mode[1] = LANE_DIV;
      end
      for (int l = 0; l < 2; l++) begin
         num_mag[l] = sel_num[l][NW-1] ? NW'(-sel_num[l]) : NW'(sel_num[l]);
         den_mag[l] = sel_den[l][NW-1] ? NW'(-sel_den[l]) : NW'(sel_den[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++) begin
            n6_ff[l]    <= RW'(num_mag[l]) << WEIGHT_FRAC_BITS;
            dn6_ff[l]   <= den_mag[l];
            neg6_ff[l]  <= sel_num[l][NW-1] ^ sel_den[l][NW-1];
            mode6_ff[l] <= sel_mode[l];
         end
         deg6_ff <= is_deg;
      end
   end

   // stage 7 and quotient stages: overflow test, then one quotient bit per stage
   logic [RW-1:0] rem_ff [QUOT_BITS+1][2];
   logic [NW-1:0] den_ff [QUOT_BITS+1][2];
   logic [QUOT_BITS-1:0] quo_ff [QUOT_BITS+1][2];
   logic ovf_ff [QUOT_BITS+1][2];
   logic neg_ff [QUOT_BITS+1][2];
   lane_mode_type mode_ff [QUOT_BITS+1][2];
   logic deg_ff [QUOT_BITS+1];
   logic vq_ff [QUOT_BITS+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++) begin
            rem_ff[0][l]  <= n6_ff[l];
            den_ff[0][l]  <= dn6_ff[l];
            quo_ff[0][l]  <= '0;
            ovf_ff[0][l]  <= n6_ff[l] >= (RW'(dn6_ff[l]) << QUOT_BITS);
            neg_ff[0][l]  <= neg6_ff[l];
            mode_ff[0][l] <= mode6_ff[l];
         end
         deg_ff[0] <= deg6_ff;
      end
   end

   for (genvar j = 1; j <= QUOT_BITS; j++) begin : g_div
      localparam int K = QUOT_BITS - j;
      logic [RW-1:0] shifted [2];
      logic fits [2];

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            shifted[l] = RW'(den_ff[j-1][l]) << K;
            fits[l]    = rem_ff[j-1][l] >= shifted[l];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int l = 0; l < 2; l++) begin
               rem_ff[j][l]    <= fits[l] ? rem_ff[j-1][l] - shifted[l] : rem_ff[j-1][l];
               quo_ff[j][l]    <= quo_ff[j-1][l] | (QUOT_BITS'(fits[l]) << K);
               den_ff[j][l]    <= den_ff[j-1][l];
               ovf_ff[j][l]    <= ovf_ff[j-1][l];
               neg_ff[j][l]    <= neg_ff[j-1][l];
               mode_ff[j][l]   <= mode_ff[j-1][l];
            end
            deg_ff[j] <= deg_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vq_ff[j] <= 1'b0;
         end else if (adv) begin
            vq_ff[j] <= vq_ff[j-1];
         end
      end
   end

   // saturation of the two quotients
   localparam logic [QUOT_BITS-1:0] NEG_LIMIT = QUOT_BITS'(1) << (WW - 1);
   logic signed [WW-1:0] lane_w [2];
   logic signed [WW-1:0] wb_ff, wc_ff;
   logic degf_ff, vf_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         case (mode_ff[QUOT_BITS][l])
            LANE_ZERO: lane_w[l] = '0;
            LANE_HALF: lane_w[l] = WW'(1) << (WEIGHT_FRAC_BITS - 1);
            LANE_DIV: begin
               if (!neg_ff[QUOT_BITS][l]) begin
                  if (ovf_ff[QUOT_BITS][l] || quo_ff[QUOT_BITS][l][QUOT_BITS-1]) begin
                     lane_w[l] = {1'b0, {(WW-1){1'b1}}};
                  end else begin
                     lane_w[l] = WW'(quo_ff[QUOT_BITS][l]);
                  end
               end else begin
                  if (ovf_ff[QUOT_BITS][l] || quo_ff[QUOT_BITS][l] > NEG_LIMIT) begin
                     lane_w[l] = {1'b1, {(WW-1){1'b0}}};
                  end else begin
                     lane_w[l] = -WW'(quo_ff[QUOT_BITS][l]);
                  end
               end
            end
            default: lane_w[l] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wb_ff   <= lane_w[0];
         wc_ff   <= lane_w[1];
         degf_ff <= deg_ff[QUOT_BITS];
      end
   end

   // output register: weight a from the saturated b and c
   logic signed [SW-1:0] wa_sum;
   logic signed [WW-1:0] wa_sat;
   logic signed [WW-1:0] wa_ff, wbo_ff, wco_ff;
   logic dego_ff, vo_ff;

   always_comb begin
      wa_sum = (SW'(1) <<< WEIGHT_FRAC_BITS) - SW'(wb_ff) - SW'(wc_ff);
      if (wa_sum > $signed(SW'({1'b0, {(WW-1){1'b1}}}))) begin
         wa_sat = {1'b0, {(WW-1){1'b1}}};
      end else if (wa_sum < -(SW'(1) <<< (WW - 1))) begin
         wa_sat = {1'b1, {(WW-1){1'b0}}};
      end else begin
         wa_sat = WW'(wa_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wa_ff   <= wa_sat;
         wbo_ff  <= wb_ff;
         wco_ff  <= wc_ff;
         dego_ff <= degf_ff;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         v6_ff    <= 1'b0;
         vq_ff[0] <= 1'b0;
         vf_ff    <= 1'b0;
         vo_ff    <= 1'b0;
      end else if (adv) begin
         v1_ff    <= req_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         v6_ff    <= v5_ff;
         vq_ff[0] <= v6_ff;
         vf_ff    <= vq_ff[QUOT_BITS];
         vo_ff    <= vf_ff;
      end
   end

   assign rsp_valid      = vo_ff;
   assign rsp_weight_a   = wa_ff;
   assign rsp_weight_b   = wbo_ff;
   assign rsp_weight_c   = wco_ff;
   assign rsp_degenerate = dego_ff;

   a_deg_one_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> (rsp_weight_b == '0 || rsp_weight_c == '0))
      else $error("degenerate result with both edge weights set");

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready does not follow the output register");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_weight_a))
      else $error("stalled transaction changed");

endmodule

@@ tb/tb_triangle_barycentric_coords.sv @@
// self-checking testbench for the triangle barycentric weight pipeline
`timescale 1ns / 1ps
module tb_triangle_barycentric_coords;
   import tbc_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int FB = WEIGHT_FRAC_BITS_DEF;
   localparam int LATENCY = 41;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef logic signed [CW-1:0] coord_t;
   typedef struct {
      coord_t c[12];
   } query_t;
   typedef struct {
      logic signed [31:0] wa, wb, wc;
      logic deg;
   } weights_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   coord_t req_c[12];
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_weight_a, rsp_weight_b, rsp_weight_c;
   logic rsp_degenerate;
   logic csr_write_enable = 0;
   logic [THRESH_WIDTH-1:0] csr_write_data = '0;

   logic [31:0] threshold = THRESH_RESET;
   weights_t expected_weights[$];
   int errors = 0;
   int idle_cycles = 0;
   int hold_off = 0;
   bit stall_mode = 1;

   always #1 clock = ~clock;

   initial for (int i = 0; i < 12; i++) req_c[i] = '0;

   triangle_barycentric_coords dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_x(req_c[0]), .req_a_y(req_c[1]), .req_a_z(req_c[2]),
      .req_b_x(req_c[3]), .req_b_y(req_c[4]), .req_b_z(req_c[5]),
      .req_c_x(req_c[6]), .req_c_y(req_c[7]), .req_c_z(req_c[8]),
      .req_p_x(req_c[9]), .req_p_y(req_c[10]), .req_p_z(req_c[11]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_weight_a(rsp_weight_a), .rsp_weight_b(rsp_weight_b),
      .rsp_weight_c(rsp_weight_c), .rsp_degenerate(rsp_degenerate),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   // num * 2^FB / den, truncated, saturated
   function automatic longint quot_sat(logic signed [127:0] num, logic signed [127:0] den);
      logic [127:0] n, d, q;
      bit neg;
      neg = num[127] != den[127];
      n = num[127] ? -num : num;
      d = den[127] ? -den : den;
      q = (n << FB) / d;
      if (!neg) return (q > 128'h7FFFFFFF) ? 64'sd2147483647 : longint'(q[31:0]);
      return (q > 128'h80000000) ? -64'sd2147483648 : -longint'(q[32:0]);
   endfunction

   function automatic longint edge_fraction(logic signed [63:0] along, logic signed [63:0] len2);
      if (len2 == 0) return longint'(1) << (FB - 1);
      return quot_sat(128'(along), 128'(len2));
   endfunction

   function automatic weights_t solve_weights(query_t q);
      logic signed [63:0] e0[3], e1[3], v[3];
      logic signed [63:0] d00, d01, d11, d20, d21;
      logic signed [127:0] det, mag;
      longint wa, wb, wc;
      weights_t w;
      for (int i = 0; i < 3; i++) begin
         e0[i] = 64'(q.c[3+i]) - 64'(q.c[i]);
         e1[i] = 64'(q.c[6+i]) - 64'(q.c[i]);
         v[i]  = 64'(q.c[9+i]) - 64'(q.c[i]);
      end
      d00 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
      d01 = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
      d11 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
      d20 = v[0]*e0[0] + v[1]*e0[1] + v[2]*e0[2];
      d21 = v[0]*e1[0] + v[1]*e1[1] + v[2]*e1[2];
      det = 128'(d00) * 128'(d11) - 128'(d01) * 128'(d01);
      mag = det[127] ? -det : det;
      if (mag <= 128'(threshold)) begin
         w.deg = 1;
         if (d00 > d11) begin
            wb = edge_fraction(d20, d00);
            wc = 0;
         end else begin
            wc = edge_fraction(d21, d11);
            wb = 0;
         end
      end else begin
         w.deg = 0;
         wb = quot_sat(128'(d11) * 128'(d20) - 128'(d01) * 128'(d21), det);
         wc = quot_sat(128'(d00) * 128'(d21) - 128'(d01) * 128'(d20), det);
      end
      wa = (longint'(1) << FB) - wb - wc;
      if (wa > 64'sd2147483647) wa = 64'sd2147483647;
      if (wa < -64'sd2147483648) wa = -64'sd2147483648;
      w.wa = wa[31:0];
      w.wb = wb[31:0];
      w.wc = wc[31:0];
      return w;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", field, got, want);
      errors++;
   endtask

   function automatic int random_gap();
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_query(query_t q, bit gaps);
      int gap;
      gap = gaps ? random_gap() : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      for (int i = 0; i < 12; i++) req_c[i] <= q.c[i];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_weights.push_back(solve_weights(q));
   endtask

   // response side: random stalls, a long hold-off when requested, or always ready when stalls are off
   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 0;
         hold_off <= hold_off - 1;
      end else if (stall_mode)
         rsp_ready <= ($urandom_range(0, 5) != 0) || ($urandom_range(0, 40) == 0 ? 0 : 1) == 0;
      else
         rsp_ready <= 1;
   end

   always @(posedge clock) begin
      weights_t w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_weights.size() == 0) begin
            $display("unexpected transaction on the result side");
            errors++;
         end else begin
            w = expected_weights.pop_front();
            if (rsp_weight_a !== w.wa) report_mismatch("weight_a", rsp_weight_a, w.wa);
            if (rsp_weight_b !== w.wb) report_mismatch("weight_b", rsp_weight_b, w.wb);
            if (rsp_weight_c !== w.wc) report_mismatch("weight_c", rsp_weight_c, w.wc);
            if (rsp_degenerate !== w.deg) report_mismatch("degenerate", rsp_degenerate, w.deg);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset || hold_off > 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic drain();
      req_valid <= 0;
      while (expected_weights.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_threshold(logic [31:0] value);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      threshold = value;
   endtask

   function automatic coord_t rand_coord(int span);
      case ($urandom_range(0, 9))
         0: return coord_t'(-32768);
         1: return coord_t'(32767);
         2: return coord_t'($urandom);
         default: return coord_t'($urandom_range(0, 2 * span) - span);
      endcase
   endfunction

   function automatic query_t random_query();
      query_t q;
      int span;
      span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(4, 3000);
      for (int i = 0; i < 12; i++) q.c[i] = rand_coord(span);
      case ($urandom_range(0, 7))
         0: for (int i = 0; i < 3; i++) q.c[3+i] = q.c[i];       // ab collapsed
         1: for (int i = 0; i < 3; i++) q.c[6+i] = q.c[i];       // ac collapsed
         2: for (int i = 0; i < 3; i++) begin                    // collinear
            q.c[6+i] = coord_t'(2 * q.c[3+i] - q.c[i]);
         end
         default: ;
      endcase
      return q;
   endfunction

   function automatic query_t make_query(int a[3], int b[3], int c[3], int p[3]);
      query_t q;
      for (int i = 0; i < 3; i++) begin
         q.c[i]   = coord_t'(a[i]);
         q.c[3+i] = coord_t'(b[i]);
         q.c[6+i] = coord_t'(c[i]);
         q.c[9+i] = coord_t'(p[i]);
      end
      return q;
   endfunction

   task automatic test_directed();
      send_query(make_query('{0,0,0}, '{256,0,0}, '{0,256,0}, '{64,64,0}), 0);
      send_query(make_query('{0,0,0}, '{0,0,0}, '{0,0,0}, '{5,5,5}), 0);
      send_query(make_query('{0,0,0}, '{512,0,0}, '{256,0,0}, '{128,0,0}), 0);
      send_query(make_query('{0,0,0}, '{256,0,0}, '{512,0,0}, '{300,0,0}), 0);
      send_query(make_query('{10,10,10}, '{10,10,10}, '{300,10,10}, '{-50,0,0}), 0);
      send_query(make_query('{0,0,0}, '{256,0,0}, '{0,0,0}, '{1000,0,0}), 0);
      send_query(make_query('{-32768,-32768,-32768}, '{32767,32767,32767},
                            '{32767,-32768,32767}, '{-32768,32767,-32768}), 0);
      send_query(make_query('{32767,32767,32767}, '{-32768,-32768,-32768},
                            '{-32768,32767,-32768}, '{32767,-32768,32767}), 0);
      send_query(make_query('{0,0,0}, '{1,0,0}, '{0,1,0}, '{32767,-32768,0}), 0);
      send_query(make_query('{0,0,0}, '{32767,0,0}, '{0,32767,0}, '{-1,-1,-1}), 0);
      send_query(make_query('{-1,-1,-1}, '{-1,-1,-1}, '{-1,-1,-1}, '{-1,-1,-1}), 0);
      send_query(make_query('{0,0,0}, '{2,0,0}, '{0,2,0}, '{32767,32767,0}), 0);
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) send_query(random_query(), 1);
   endtask

   task automatic test_backpressure();
      hold_off = 300;
      for (int n = 0; n < 120; n++) send_query(random_query(), 0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(300);
      write_threshold(32'd0);
      test_directed();
      test_random(300);
      write_threshold(32'hFFFFFFFF);
      test_directed();
      test_random(200);
      write_threshold(32'd1 << 20);
      test_backpressure();
      test_random(300);
      write_threshold(THRESH_RESET);
      stall_mode = 0;
      test_random(200);
      drain();
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
